@@ hdl/dds_pkg.sv @@
// ---------------------------------------------------------------------------
// Depth sorter package
// Shared word types, field widths and the per-cycle command bundle that the
// top level broadcasts to every cell of the sorting chain.
// ---------------------------------------------------------------------------
package dds_pkg;

  localparam int unsigned KeyBits     = 24;
  localparam int unsigned IndexBits   = 10;
  localparam int unsigned ShadeBits   = 8;
  localparam int unsigned MaxEntries  = 512;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [IndexBits-1:0] corner_d;
    logic [IndexBits-1:0] corner_c;
    logic [IndexBits-1:0] corner_b;
    logic [IndexBits-1:0] corner_a;
    logic [ShadeBits-1:0] shade;
  } payload_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    payload_t           payload;
  } entry_t;

  // Input word.
  typedef struct packed {
    kind_e                kind;
    logic [KeyBits-1:0]   distance_key;
    logic [IndexBits-1:0] corner_a;
    logic [IndexBits-1:0] corner_b;
    logic [IndexBits-1:0] corner_c;
    logic [IndexBits-1:0] corner_d;
    logic [ShadeBits-1:0] shade;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [KeyBits-1:0]   out_key;
    logic [IndexBits-1:0] out_corner_a;
    logic [IndexBits-1:0] out_corner_b;
    logic [IndexBits-1:0] out_corner_c;
    logic [IndexBits-1:0] out_corner_d;
    logic [ShadeBits-1:0] out_shade;
    logic                 is_last;
    logic                 is_empty;
  } out_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic   ins;
    logic   drn;
    entry_t new_entry;
  } cell_cmd_t;

endpackage

@@ hdl/dds_cell.sv @@
// ---------------------------------------------------------------------------
// Depth sorter cell
// One slot of the sorted chain. On an insert it keeps its entry, takes the
// new word, or takes its left neighbor's entry; on a drain it takes its right
// neighbor's entry.
// ---------------------------------------------------------------------------
module dds_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dds_pkg::cell_cmd_t cmd_i,
  input  logic               left_lt_i,
  input  logic               left_valid_i,
  input  dds_pkg::entry_t    left_entry_i,
  input  logic               right_valid_i,
  input  dds_pkg::entry_t    right_entry_i,
  output logic               lt_o,
  output logic               valid_o,
  output dds_pkg::entry_t    entry_o
);

  logic            valid_q, valid_d;
  dds_pkg::entry_t entry_q, entry_d;
  logic            lt;

  // An empty slot counts as smaller than any key, so the insert point is the
  // first slot whose left neighbor is not smaller than the new key.
  assign lt = !valid_q || (entry_q.key < cmd_i.new_entry.key);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.drn) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end else if (cmd_i.ins && lt) begin
      if (left_lt_i) begin
        valid_d = left_valid_i;
        entry_d = left_entry_i;
      end else begin
        valid_d = 1'b1;
        entry_d = cmd_i.new_entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign lt_o    = lt;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

@@ hdl/descending_depth_insertion_sorter.sv @@
// ---------------------------------------------------------------------------
// Descending depth insertion sorter
// Painter's-order sorter built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   A word is taken on a rising edge with start_i high and busy_o low.
//   busy_o stays low: every cell settles an insert or a drain with a single
//   register update, so one word is taken per cycle, back to back.
//   An insert word places its key and payload so that the chain stays in
//   descending key order; equal keys leave in arrival order. An insert into
//   a full chain is dropped. Inserts give no result.
//   A drain word gives one result word in the cycle after, on res_o, marked by
//   res_valid_o for exactly one cycle: the farthest entry, with is_last set
//   when it empties the chain, or is_empty set and all else zero when the
//   chain holds nothing. The receiver cannot stall; results must be taken.
//   The result word is registered after cell zero; the rate of one word
//   per cycle is set by the cell update, which compares the broadcast key
//   with the cell's own key and picks one of three sources.
//   Reset empties the chain at once (valid bits only); no clearing pass.
// ---------------------------------------------------------------------------
module descending_depth_insertion_sorter #(
  parameter int unsigned MAX_ENTRIES = dds_pkg::MaxEntries
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dds_pkg::in_t  in_i,
  output logic          res_valid_o,
  output dds_pkg::out_t res_o
);

  dds_pkg::cell_cmd_t cmd;
  logic               accept;
  logic               full;

  logic               cell_lt    [MAX_ENTRIES];
  logic               cell_valid [MAX_ENTRIES];
  dds_pkg::entry_t    cell_entry [MAX_ENTRIES];

  logic               res_valid_q;
  dds_pkg::out_t      res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = cell_valid[MAX_ENTRIES-1];

  always_comb begin
    cmd                             = '0;
    cmd.ins                         = accept && (in_i.kind == dds_pkg::KIND_INSERT) && !full;
    cmd.drn                         = accept && (in_i.kind == dds_pkg::KIND_DRAIN);
    cmd.new_entry.key               = in_i.distance_key;
    cmd.new_entry.payload.corner_a  = in_i.corner_a;
    cmd.new_entry.payload.corner_b  = in_i.corner_b;
    cmd.new_entry.payload.corner_c  = in_i.corner_c;
    cmd.new_entry.payload.corner_d  = in_i.corner_d;
    cmd.new_entry.payload.shade     = in_i.shade;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic            left_lt, left_valid, right_valid;
    dds_pkg::entry_t left_entry, right_entry;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b0;
      assign left_valid = 1'b0;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    dds_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_lt_i     (left_lt),
      .left_valid_i  (left_valid),
      .left_entry_i  (left_entry),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .lt_o          (cell_lt[i]),
      .valid_o       (cell_valid[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    res_d = '0;
    if (cell_valid[0]) begin
      res_d.out_key      = cell_entry[0].key;
      res_d.out_corner_a = cell_entry[0].payload.corner_a;
      res_d.out_corner_b = cell_entry[0].payload.corner_b;
      res_d.out_corner_c = cell_entry[0].payload.corner_c;
      res_d.out_corner_d = cell_entry[0].payload.corner_d;
      res_d.out_shade    = cell_entry[0].payload.shade;
      res_d.is_last      = !cell_valid[1];
    end else begin
      res_d.is_empty = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd.drn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.drn) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A result word appears only in the cycle after an accepted drain word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && (in_i.kind == dds_pkg::KIND_DRAIN)))
    else $error("result word without a drain word");

  // Occupied cells form one run starting at the head; checked for the first two cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> cell_valid[0])
    else $error("gap in the cell chain");

  // The head of the chain holds a key no smaller than the second cell's.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[0] && cell_valid[1]) |-> (cell_entry[0].key >= cell_entry[1].key))
    else $error("chain out of descending order");

  // An insert into an empty chain lands in the head cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins && !cell_valid[0]) |=> (cell_valid[0] && !cell_valid[1]))
    else $error("insert into empty chain lost");

  // The empty and last flags are never set together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.is_empty && res_o.is_last))
    else $error("empty and last flags both set");

endmodule
